### design/dopq_pkg.sv
package dopq_pkg;

	localparam int HANDLE_W = 16;
	localparam int LENGTH_W = 24;
	localparam int ACT_W = 3;
	localparam int KIND_W = 3;
	localparam int CAP_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [ACT_W-1:0] ACT_PUSH = 3'd0;
	localparam logic [ACT_W-1:0] ACT_POP = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TAKE_KEY = 3'd2;
	localparam logic [ACT_W-1:0] ACT_TAKE_DROP = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLOSE = 3'd4;

	localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd0;
	localparam logic [KIND_W-1:0] KIND_POPPED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PUSH_DONE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ACK = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUDGET = 2'd1;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
	localparam logic [LENGTH_W-1:0] BUDGET_RESET = 24'(2 * 1024 * 1024);

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [LENGTH_W-1:0] length;
		logic video;
		logic key;
	} desc_t;

endpackage

### design/dopq_in_if.sv
interface dopq_in_if import dopq_pkg::*; ();
	logic valid;
	logic ready;
	logic [ACT_W-1:0] action;
	logic [HANDLE_W-1:0] pkt_handle;
	logic [LENGTH_W-1:0] pkt_length;
	logic pkt_video;
	logic pkt_key;

	modport source (output valid, action, pkt_handle, pkt_length, pkt_video, pkt_key,
		input ready);
	modport sink (input valid, action, pkt_handle, pkt_length, pkt_video, pkt_key,
		output ready);
endinterface

### design/dopq_out_if.sv
interface dopq_out_if import dopq_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] result_kind;
	logic [HANDLE_W-1:0] out_handle;
	logic [LENGTH_W-1:0] out_length;
	logic out_video;
	logic out_key;
	logic flag_bit;
	logic [CAP_W-1:0] occupancy;
	logic [LENGTH_W-1:0] queued_bytes;
	logic is_closed;
	logic last;

	modport source (output valid, result_kind, out_handle, out_length, out_video, out_key,
		flag_bit, occupancy, queued_bytes, is_closed, last, input ready);
	modport sink (input valid, result_kind, out_handle, out_length, out_video, out_key,
		flag_bit, occupancy, queued_bytes, is_closed, last, output ready);
endinterface

### design/dopq_cfg_if.sv
interface dopq_cfg_if import dopq_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/drop_oldest_packet_queue.sv
// Sequence: pop, flag and close results are loaded into the result register from their own result
// state once the output is free. Push to an open queue: the drop walk alternates check and data
// states per dropped entry, then each release is read back out of the descriptor RAM and offered,
// and the done result follows; a lost key frame starts a flush of dependent frames in the walk.
// Throughput: one input item at a time, taken only in the idle state; a held result stalls.
// Reset: head, tail, count, byte total and flags clear; descriptor RAM is not cleared.
module drop_oldest_packet_queue import dopq_pkg::*; #(
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	dopq_cfg_if.sink cfg,
	dopq_in_if.sink pkt_in,
	dopq_out_if.source res_out
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CAP_W-1:0] capacity_q;
	logic [LENGTH_W-1:0] budget_q;

	logic rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	desc_t rd_data, wr_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			budget_q <= BUDGET_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_CAPACITY: capacity_q <= cfg.data[CAP_W-1:0];
				REG_BUDGET: budget_q <= cfg.data[LENGTH_W-1:0];
				default: ;
			endcase
		end
	end

	dopq_ctrl #(
		.DEPTH(DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.capacity(capacity_q),
		.budget(budget_q),
		.pkt_in(pkt_in),
		.res_out(res_out),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	dopq_store #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

endmodule

### design/dopq_store.sv
module dopq_store import dopq_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic rd_en,
	input logic [AW-1:0] rd_addr,
	output desc_t rd_data,
	input logic wr_en,
	input logic [AW-1:0] wr_addr,
	input desc_t wr_data
);

	desc_t mem_q [DEPTH];
	desc_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### design/dopq_ctrl.sv
module dopq_ctrl import dopq_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW = $clog2(DEPTH),
	parameter int CW = $clog2(DEPTH + 1)
) (
	input logic clk,
	input logic arst_n,
	input logic [CAP_W-1:0] capacity,
	input logic [LENGTH_W-1:0] budget,
	dopq_in_if.sink pkt_in,
	dopq_out_if.source res_out,
	output logic rd_en,
	output logic [AW-1:0] rd_addr,
	input desc_t rd_data,
	output logic wr_en,
	output logic [AW-1:0] wr_addr,
	output desc_t wr_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CL_REL = 4'd1;
	localparam logic [3:0] S_CL_DONE = 4'd2;
	localparam logic [3:0] S_ACK = 4'd3;
	localparam logic [3:0] S_POP_OUT = 4'd4;
	localparam logic [3:0] S_EMPTY = 4'd5;
	localparam logic [3:0] S_DROP_CHK = 4'd6;
	localparam logic [3:0] S_DROP_DAT = 4'd7;
	localparam logic [3:0] S_REL_RD = 4'd8;
	localparam logic [3:0] S_REL_OUT = 4'd9;
	localparam logic [3:0] S_PUSH_DONE = 4'd10;

	localparam int CMP_W = CAP_W + 1;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	logic [3:0] state_q;
	logic [ACT_W-1:0] act_q;
	desc_t pkt_q;

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [LENGTH_W-1:0] bytes_q;
	logic closed_q, key_lost_q, any_drop_q;

	// drop walk
	logic [AW-1:0] wh_q, rp_q;
	logic [CW-1:0] wc_q, ndrop_q;
	logic [LENGTH_W-1:0] wb_q;
	logic wk_q, dropped_q, flush_q;

	// result register
	logic ov_q;
	logic [KIND_W-1:0] o_kind_q;
	desc_t o_desc_q;
	logic o_flag_q;
	logic [CAP_W-1:0] o_occ_q;
	logic [LENGTH_W-1:0] o_bytes_q;
	logic o_closed_q, o_last_q;

	logic accept, out_free, over_budget, first_go, drop_now, res_load;
	logic [CMP_W-1:0] cap_eff;

	assign accept = pkt_in.valid && pkt_in.ready;
	assign pkt_in.ready = (state_q == S_IDLE);
	assign out_free = !ov_q || res_out.ready;
	assign res_load = out_free && (state_q inside {S_CL_REL, S_CL_DONE, S_ACK, S_POP_OUT,
		S_EMPTY, S_REL_OUT, S_PUSH_DONE});

	always_comb begin
		if (capacity == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
			cap_eff = CMP_W'(DEPTH);
		end else begin
			cap_eff = CMP_W'(capacity);
		end
	end

	assign over_budget = ({1'b0, wb_q} + {1'b0, pkt_q.length}) > {1'b0, budget};
	assign first_go = (wc_q != '0) && ((CMP_W'(wc_q) >= cap_eff) || over_budget);
	assign drop_now = !flush_q || (rd_data.video && !rd_data.key);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = head_q;
		unique case (state_q)
			S_IDLE: begin
				rd_en = accept && (pkt_in.action == ACT_POP) && (count_q != '0);
				rd_addr = head_q;
			end
			S_DROP_CHK: begin
				rd_en = flush_q ? (wc_q != '0) : first_go;
				rd_addr = wh_q;
			end
			S_REL_RD: begin
				rd_en = (ndrop_q != '0);
				rd_addr = rp_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	assign wr_en = (state_q == S_PUSH_DONE) && out_free;
	assign wr_addr = tail_q;
	assign wr_data = pkt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= ACT_PUSH;
			pkt_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			bytes_q <= '0;
			closed_q <= 1'b0;
			key_lost_q <= 1'b0;
			any_drop_q <= 1'b0;
			wh_q <= '0;
			rp_q <= '0;
			wc_q <= '0;
			ndrop_q <= '0;
			wb_q <= '0;
			wk_q <= 1'b0;
			dropped_q <= 1'b0;
			flush_q <= 1'b0;
			ov_q <= 1'b0;
			o_kind_q <= KIND_RELEASE;
			o_desc_q <= '0;
			o_flag_q <= 1'b0;
			o_occ_q <= '0;
			o_bytes_q <= '0;
			o_closed_q <= 1'b0;
			o_last_q <= 1'b0;
		end else begin
			if (ov_q && res_out.ready && !res_load) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q <= pkt_in.action;
						pkt_q <= '{handle: pkt_in.pkt_handle, length: pkt_in.pkt_length,
							video: pkt_in.pkt_video, key: pkt_in.pkt_key};
						unique case (pkt_in.action) inside
							ACT_PUSH: begin
								if (closed_q) begin
									state_q <= S_CL_REL;
								end else begin
									wh_q <= head_q;
									wc_q <= count_q;
									wb_q <= bytes_q;
									wk_q <= key_lost_q;
									dropped_q <= 1'b0;
									flush_q <= 1'b0;
									ndrop_q <= '0;
									state_q <= S_DROP_CHK;
								end
							end
							ACT_POP: begin
								state_q <= (count_q != '0) ? S_POP_OUT : S_EMPTY;
							end
							ACT_TAKE_KEY, ACT_TAKE_DROP, ACT_CLOSE: begin
								state_q <= S_ACK;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CL_REL: begin
					if (out_free) begin
						ov_q <= 1'b1;
						o_kind_q <= KIND_RELEASE;
						o_desc_q <= pkt_q;
						o_flag_q <= 1'b0;
						o_occ_q <= CAP_W'(count_q);
						o_bytes_q <= bytes_q;
						o_closed_q <= closed_q;
						o_last_q <= 1'b0;
						state_q <= S_CL_DONE;
					end
				end
				S_CL_DONE: begin
					if (out_free) begin
						ov_q <= 1'b1;
						o_kind_q <= KIND_PUSH_DONE;
						o_desc_q <= '0;
						o_flag_q <= 1'b0;
						o_occ_q <= CAP_W'(count_q);
						o_bytes_q <= bytes_q;
						o_closed_q <= closed_q;
						o_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_ACK: begin
					if (out_free) begin
						ov_q <= 1'b1;
						o_kind_q <= KIND_ACK;
						o_desc_q <= '0;
						o_flag_q <= (act_q == ACT_TAKE_KEY) ? key_lost_q :
							(act_q == ACT_TAKE_DROP) ? any_drop_q : 1'b0;
						o_occ_q <= CAP_W'(count_q);
						o_bytes_q <= bytes_q;
						o_closed_q <= closed_q || (act_q == ACT_CLOSE);
						o_last_q <= 1'b1;
						if (act_q == ACT_TAKE_KEY) begin
							key_lost_q <= 1'b0;
						end
						if (act_q == ACT_TAKE_DROP) begin
							any_drop_q <= 1'b0;
						end
						if (act_q == ACT_CLOSE) begin
							closed_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_POP_OUT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						o_kind_q <= KIND_POPPED;
						o_desc_q <= rd_data;
						o_flag_q <= 1'b0;
						o_occ_q <= CAP_W'(count_q - 1'b1);
						o_bytes_q <= bytes_q - rd_data.length;
						o_closed_q <= closed_q;
						o_last_q <= 1'b1;
						count_q <= count_q - 1'b1;
						bytes_q <= bytes_q - rd_data.length;
						head_q <= next_idx(head_q);
						state_q <= S_IDLE;
					end
				end
				S_EMPTY: begin
					if (out_free) begin
						ov_q <= 1'b1;
						o_kind_q <= KIND_EMPTY;
						o_desc_q <= '0;
						o_flag_q <= 1'b0;
						o_occ_q <= CAP_W'(count_q);
						o_bytes_q <= bytes_q;
						o_closed_q <= closed_q;
						o_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DROP_CHK: begin
					if (flush_q ? (wc_q != '0) : first_go) begin
						state_q <= S_DROP_DAT;
					end else if (!flush_q && dropped_q && wk_q) begin
						flush_q <= 1'b1;
					end else begin
						// walk done: commit new head and totals, replay releases from old head
						head_q <= wh_q;
						count_q <= wc_q + 1'b1;
						bytes_q <= wb_q + pkt_q.length;
						key_lost_q <= wk_q;
						any_drop_q <= any_drop_q || dropped_q;
						rp_q <= head_q;
						state_q <= S_REL_RD;
					end
				end
				S_DROP_DAT: begin
					if (drop_now) begin
						wb_q <= wb_q - rd_data.length;
						wc_q <= wc_q - 1'b1;
						wh_q <= next_idx(wh_q);
						ndrop_q <= ndrop_q + 1'b1;
						if (!flush_q) begin
							wk_q <= wk_q || (rd_data.video && rd_data.key);
							dropped_q <= 1'b1;
						end
						state_q <= S_DROP_CHK;
					end else begin
						head_q <= wh_q;
						count_q <= wc_q + 1'b1;
						bytes_q <= wb_q + pkt_q.length;
						key_lost_q <= wk_q;
						any_drop_q <= any_drop_q || dropped_q;
						rp_q <= head_q;
						state_q <= S_REL_RD;
					end
				end
				S_REL_RD: begin
					state_q <= (ndrop_q != '0) ? S_REL_OUT : S_PUSH_DONE;
				end
				S_REL_OUT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						o_kind_q <= KIND_RELEASE;
						o_desc_q <= rd_data;
						o_flag_q <= 1'b0;
						o_occ_q <= CAP_W'(count_q);
						o_bytes_q <= bytes_q;
						o_closed_q <= closed_q;
						o_last_q <= 1'b0;
						rp_q <= next_idx(rp_q);
						ndrop_q <= ndrop_q - 1'b1;
						state_q <= S_REL_RD;
					end
				end
				S_PUSH_DONE: begin
					// tail written only after all releases are read out
					if (out_free) begin
						tail_q <= next_idx(tail_q);
						ov_q <= 1'b1;
						o_kind_q <= KIND_PUSH_DONE;
						o_desc_q <= '0;
						o_flag_q <= dropped_q;
						o_occ_q <= CAP_W'(count_q);
						o_bytes_q <= bytes_q;
						o_closed_q <= closed_q;
						o_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_out.valid = ov_q;
	assign res_out.result_kind = o_kind_q;
	assign res_out.out_handle = o_desc_q.handle;
	assign res_out.out_length = o_desc_q.length;
	assign res_out.out_video = o_desc_q.video;
	assign res_out.out_key = o_desc_q.key;
	assign res_out.flag_bit = o_flag_q;
	assign res_out.occupancy = o_occ_q;
	assign res_out.queued_bytes = o_bytes_q;
	assign res_out.is_closed = o_closed_q;
	assign res_out.last = o_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (bytes_q == '0))
		else $error("bytes held with no entries");

	a_release_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !(o_last_q && (o_kind_q == KIND_RELEASE)))
		else $error("release closed a step");

	a_push_keeps_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && (o_kind_q == KIND_PUSH_DONE) && !o_closed_q) |-> (o_occ_q != '0))
		else $error("push done with empty queue");

	a_dat_after_chk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DROP_DAT) |-> $past(state_q == S_DROP_CHK && rd_en))
		else $error("drop data without read");

endmodule

### bench/drop_oldest_packet_queue_tb.sv
module drop_oldest_packet_queue_tb import dopq_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 32;
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned IDLE_LOW = 30;
	localparam int unsigned IDLE_HIGH = 75;

	typedef struct {
		logic [ACT_W-1:0] action;
		logic [HANDLE_W-1:0] handle;
		logic [LENGTH_W-1:0] length;
		logic video;
		logic key;
	} pkt_cmd_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [HANDLE_W-1:0] handle;
		logic [LENGTH_W-1:0] length;
		logic video;
		logic key;
		logic flag;
		logic [CAP_W-1:0] occupancy;
		logic [LENGTH_W-1:0] queued_bytes;
		logic closed;
		logic last;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n;

	dopq_cfg_if cfg_bus ();
	dopq_in_if pkt_bus ();
	dopq_out_if res_bus ();

	drop_oldest_packet_queue #(.DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.pkt_in(pkt_bus),
		.res_out(res_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// descriptor ring mirror
	desc_t ring [DEPTH];
	int unsigned ring_head = 0;
	int unsigned ring_tail = 0;
	int unsigned ring_count = 0;
	logic [LENGTH_W-1:0] ring_bytes = '0;
	logic closed_q = 1'b0;
	logic key_lost_q = 1'b0;
	logic any_drop_q = 1'b0;
	logic [CAP_W-1:0] cap_reg = CAP_RESET;
	logic [LENGTH_W-1:0] budget_reg = BUDGET_RESET;

	queue_result_t step_buf[$];
	queue_result_t results_due[$];
	pkt_cmd_t actions_to_send[$];
	pkt_cmd_t cmd_on_bus;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned actions_sent = 0;
	int unsigned results_seen = 0;
	int unsigned releases_seen = 0;
	int unsigned reg_writes = 0;

	function automatic queue_result_t make_result(logic [KIND_W-1:0] kind, desc_t d, logic flag);
		queue_result_t r;
		r.kind = kind;
		r.handle = d.handle;
		r.length = d.length;
		r.video = d.video;
		r.key = d.key;
		r.flag = flag;
		r.occupancy = '0;
		r.queued_bytes = '0;
		r.closed = 1'b0;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void release_oldest();
		step_buf.push_back(make_result(KIND_RELEASE, ring[ring_head], 1'b0));
		if (ring[ring_head].video && ring[ring_head].key)
			key_lost_q = 1'b1;
		ring_bytes = ring_bytes - ring[ring_head].length;
		ring_head = (ring_head + 1) % DEPTH;
		ring_count--;
	endfunction

	function automatic void apply_action(pkt_cmd_t c);
		int unsigned cap_now;
		logic dropped;
		desc_t d;
		d.handle = c.handle;
		d.length = c.length;
		d.video = c.video;
		d.key = c.key;
		cap_now = (cap_reg == 0) ? 1 : (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
		dropped = 1'b0;
		step_buf.delete();
		case (c.action)
			ACT_PUSH: begin
				if (closed_q) begin
					step_buf.push_back(make_result(KIND_RELEASE, d, 1'b0));
					step_buf.push_back(make_result(KIND_PUSH_DONE, '0, 1'b0));
				end else begin
					while (ring_count > 0 && (ring_count >= cap_now ||
							{1'b0, ring_bytes} + {1'b0, c.length} > {1'b0, budget_reg})) begin
						release_oldest();
						any_drop_q = 1'b1;
						dropped = 1'b1;
					end
					// key frame gone: the dependent frames at the head go too
					if (dropped && key_lost_q)
						while (ring_count > 0 && ring[ring_head].video && !ring[ring_head].key)
							release_oldest();
					ring[ring_tail] = d;
					ring_tail = (ring_tail + 1) % DEPTH;
					ring_count++;
					ring_bytes = ring_bytes + c.length;
					step_buf.push_back(make_result(KIND_PUSH_DONE, '0, dropped));
				end
			end
			ACT_POP: begin
				if (ring_count > 0) begin
					step_buf.push_back(make_result(KIND_POPPED, ring[ring_head], 1'b0));
					ring_bytes = ring_bytes - ring[ring_head].length;
					ring_head = (ring_head + 1) % DEPTH;
					ring_count--;
				end else begin
					step_buf.push_back(make_result(KIND_EMPTY, '0, 1'b0));
				end
			end
			ACT_TAKE_KEY: begin
				step_buf.push_back(make_result(KIND_ACK, '0, key_lost_q));
				key_lost_q = 1'b0;
			end
			ACT_TAKE_DROP: begin
				step_buf.push_back(make_result(KIND_ACK, '0, any_drop_q));
				any_drop_q = 1'b0;
			end
			ACT_CLOSE: begin
				closed_q = 1'b1;
				step_buf.push_back(make_result(KIND_ACK, '0, 1'b0));
			end
			default: ;
		endcase
		foreach (step_buf[i]) begin
			step_buf[i].occupancy = CAP_W'(ring_count);
			step_buf[i].queued_bytes = ring_bytes;
			step_buf[i].closed = closed_q;
			step_buf[i].last = (i == step_buf.size() - 1);
			results_due.push_back(step_buf[i]);
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic pkt_cmd_t push_of(logic [HANDLE_W-1:0] h, logic [LENGTH_W-1:0] len,
			logic v, logic k);
		pkt_cmd_t c;
		c.action = ACT_PUSH;
		c.handle = h;
		c.length = len;
		c.video = v;
		c.key = k;
		return c;
	endfunction

	// payload fields of non-push actions carry noise
	function automatic pkt_cmd_t ctrl_of(logic [ACT_W-1:0] act);
		pkt_cmd_t c;
		c = push_of(HANDLE_W'($urandom), LENGTH_W'($urandom), 1'($urandom), 1'($urandom));
		c.action = act;
		return c;
	endfunction

	// input driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (pkt_bus.valid && pkt_bus.ready) begin
				apply_action(cmd_on_bus);
				actions_sent++;
			end
			if (!pkt_bus.valid || pkt_bus.ready) begin
				if (actions_to_send.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					cmd_on_bus = actions_to_send.pop_front();
					pkt_bus.valid <= 1'b1;
					pkt_bus.action <= cmd_on_bus.action;
					pkt_bus.pkt_handle <= cmd_on_bus.handle;
					pkt_bus.pkt_length <= cmd_on_bus.length;
					pkt_bus.pkt_video <= cmd_on_bus.video;
					pkt_bus.pkt_key <= cmd_on_bus.key;
				end else begin
					pkt_bus.valid <= 1'b0;
				end
			end
		end
	end

	// result ready, with long hold-offs on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_requests) begin
				hold_seen <= hold_requests;
				hold_left <= HOLD_CYCLES;
				res_bus.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// result checker
	always @(posedge clk) begin : check_results
		queue_result_t due;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			results_seen++;
			if (res_bus.result_kind == KIND_RELEASE)
				releases_seen++;
			if (results_due.size() == 0) begin
				$error("unexpected result transfer: kind %0d handle 0x%0h",
					res_bus.result_kind, res_bus.out_handle);
				mismatches++;
			end else begin
				due = results_due.pop_front();
				check_field("result_kind", 32'(due.kind), 32'(res_bus.result_kind));
				check_field("out_handle", 32'(due.handle), 32'(res_bus.out_handle));
				check_field("out_length", 32'(due.length), 32'(res_bus.out_length));
				check_field("out_video", 32'(due.video), 32'(res_bus.out_video));
				check_field("out_key", 32'(due.key), 32'(res_bus.out_key));
				check_field("flag_bit", 32'(due.flag), 32'(res_bus.flag_bit));
				check_field("occupancy", 32'(due.occupancy), 32'(res_bus.occupancy));
				check_field("queued_bytes", 32'(due.queued_bytes), 32'(res_bus.queued_bytes));
				check_field("is_closed", 32'(due.closed), 32'(res_bus.is_closed));
				check_field("last", 32'(due.last), 32'(res_bus.last));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pkt_bus.valid && pkt_bus.ready) || (res_bus.valid && res_bus.ready) ||
					(cfg_bus.valid && cfg_bus.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$error("no transfer for %0d cycles, %0d results outstanding",
					WATCHDOG_LIMIT, results_due.size());
				$display("Mismatches found");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic drain();
		do @(negedge clk);
		while (actions_to_send.size() != 0 || pkt_bus.valid || results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		do @(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == REG_CAPACITY)
			cap_reg = val[CAP_W-1:0];
		else
			budget_reg = val[LENGTH_W-1:0];
		reg_writes++;
	endtask

	task automatic reconfigure(input logic [CAP_W-1:0] cap, input logic [LENGTH_W-1:0] budget);
		drain();
		write_reg(REG_CAPACITY, {(CFG_DATA_W-CAP_W)'($urandom), cap});
		write_reg(REG_BUDGET, budget);
		@(negedge clk);
	endtask

	task automatic add_random_traffic(input int unsigned n);
		int unsigned made;
		int unsigned frames;
		int unsigned pick;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// group of pictures: key frame, dependent frames, some audio
				frames = $urandom_range(1, 5);
				actions_to_send.push_back(push_of(HANDLE_W'($urandom),
					LENGTH_W'($urandom_range(500, 4000)), 1'b1, 1'b1));
				made++;
				repeat (frames) begin
					actions_to_send.push_back(push_of(HANDLE_W'($urandom),
						LENGTH_W'($urandom_range(50, 1500)), 1'b1, 1'b0));
					made++;
					if ($urandom_range(0, 99) < 30) begin
						actions_to_send.push_back(push_of(HANDLE_W'($urandom),
							LENGTH_W'($urandom_range(20, 300)), 1'b0, 1'($urandom)));
						made++;
					end
				end
			end else if (pick < 75) begin
				frames = $urandom_range(1, 3);
				repeat (frames) begin
					actions_to_send.push_back(ctrl_of(ACT_POP));
					made++;
				end
			end else if (pick < 85) begin
				actions_to_send.push_back(ctrl_of($urandom_range(0, 1) ? ACT_TAKE_KEY
					: ACT_TAKE_DROP));
				made++;
			end else if (pick < 93) begin
				actions_to_send.push_back(push_of(HANDLE_W'($urandom), LENGTH_W'($urandom),
					1'($urandom), 1'($urandom)));
				made++;
			end else begin
				actions_to_send.push_back(ctrl_of(ACT_W'($urandom_range(ACT_SPARE_LO,
					ACT_SPARE_HI))));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pkt_bus.valid = 1'b0;
		pkt_bus.action = ACT_PUSH;
		pkt_bus.pkt_handle = '0;
		pkt_bus.pkt_length = '0;
		pkt_bus.pkt_video = 1'b0;
		pkt_bus.pkt_key = 1'b0;
		res_bus.ready = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_CAPACITY;
		cfg_bus.data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = IDLE_LOW;
		rx_idle_pct = IDLE_HIGH;

		// reset settings: empty pop, clear flags, oversize push, drop of a key frame
		actions_to_send.push_back(ctrl_of(ACT_POP));
		actions_to_send.push_back(ctrl_of(ACT_TAKE_KEY));
		actions_to_send.push_back(ctrl_of(ACT_TAKE_DROP));
		for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
			actions_to_send.push_back(ctrl_of(ACT_W'(a)));
		actions_to_send.push_back(push_of(16'hFFFF, 24'hFFFFFF, 1'b1, 1'b1));
		actions_to_send.push_back(push_of(16'h0000, 24'h000000, 1'b0, 1'b0));
		actions_to_send.push_back(ctrl_of(ACT_TAKE_DROP));
		actions_to_send.push_back(ctrl_of(ACT_TAKE_KEY));

		// slot cap forces out a key frame; its dependent frames are flushed
		reconfigure(6'd3, 24'hFFFFFF);
		actions_to_send.push_back(push_of(16'h1111, 24'd100, 1'b1, 1'b1));
		actions_to_send.push_back(push_of(16'h2222, 24'd200, 1'b1, 1'b0));
		actions_to_send.push_back(push_of(16'h3333, 24'd300, 1'b1, 1'b0));
		actions_to_send.push_back(push_of(16'h4444, 24'd400, 1'b0, 1'b0));
		actions_to_send.push_back(ctrl_of(ACT_TAKE_KEY));
		actions_to_send.push_back(ctrl_of(ACT_POP));
		actions_to_send.push_back(ctrl_of(ACT_POP));
		actions_to_send.push_back(ctrl_of(ACT_TAKE_DROP));

		// cap of zero acts as one, budget of one byte
		reconfigure(6'd0, 24'd1);
		actions_to_send.push_back(push_of(16'h00FF, 24'd1, 1'b0, 1'b1));
		actions_to_send.push_back(push_of(16'hFF00, 24'd0, 1'b1, 1'b0));
		actions_to_send.push_back(push_of(16'h5A5A, 24'd1, 1'b1, 1'b1));
		actions_to_send.push_back(ctrl_of(ACT_POP));

		// cap above depth, then lowered below occupancy, then a smaller budget
		reconfigure(6'd63, 24'hFFFFFF);
		repeat (8)
			actions_to_send.push_back(push_of(HANDLE_W'($urandom),
				LENGTH_W'($urandom_range(1, 60)), 1'($urandom), 1'($urandom)));
		reconfigure(6'd4, 24'hFFFFFF);
		actions_to_send.push_back(push_of(16'hA5A5, 24'd10, 1'b1, 1'b0));
		reconfigure(6'd4, 24'd100);
		actions_to_send.push_back(push_of(16'h7E7E, 24'd50, 1'b0, 1'b0));
		actions_to_send.push_back(ctrl_of(ACT_POP));
		actions_to_send.push_back(ctrl_of(ACT_POP));

		reconfigure(CAP_W'($urandom_range(3, 10)), LENGTH_W'($urandom_range(3000, 12000)));
		add_random_traffic(30);

		// output held off while the sender keeps offering
		reconfigure(6'd32, 24'hFFFFFF);
		tx_idle_pct = IDLE_HIGH;
		rx_idle_pct = IDLE_LOW;
		hold_requests++;
		add_random_traffic(25);

		reconfigure(CAP_W'($urandom_range(1, 32)), LENGTH_W'($urandom_range(2000, 20000)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		add_random_traffic(25);

		reconfigure(6'd2, 24'd500);
		add_random_traffic(15);

		// closing is permanent, so it comes last
		reconfigure(6'd32, BUDGET_RESET);
		actions_to_send.push_back(push_of(16'hBEEF, 24'd64, 1'b1, 1'b1));
		actions_to_send.push_back(ctrl_of(ACT_CLOSE));
		actions_to_send.push_back(push_of(16'hC0DE, 24'hABCDEF, 1'b1, 1'b0));
		actions_to_send.push_back(ctrl_of(ACT_POP));
		actions_to_send.push_back(ctrl_of(ACT_POP));
		actions_to_send.push_back(ctrl_of(ACT_TAKE_KEY));
		actions_to_send.push_back(ctrl_of(ACT_TAKE_DROP));
		actions_to_send.push_back(ctrl_of(ACT_CLOSE));
		drain();

		$display("Run: %0d actions, %0d results checked, %0d descriptors released, %0d reg writes",
			actions_sent, results_seen, releases_seen, reg_writes);
		$display("Slot caps 0..63, budgets 1..max, key-loss flushes, long output stall, closed queue");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
